@@ rtl/core/fflsp_pkg.sv @@
package fflsp_pkg;

	// Handles are eight bits wide, so the free list never holds more than this many entries.
	localparam int unsigned FIFO_DEPTH = 256;
	localparam int unsigned SLOT_W     = 8;
	localparam int unsigned COUNT_W    = 9;

	localparam logic [1:0] ACT_ALLOC     = 2'd0;
	localparam logic [1:0] ACT_TRY_ALLOC = 2'd1;
	localparam logic [1:0] ACT_RELEASE   = 2'd2;

	localparam logic [1:0] STAT_GRANTED  = 2'd0;
	localparam logic [1:0] STAT_RELEASED = 2'd1;
	localparam logic [1:0] STAT_NONE     = 2'd2;
	localparam logic [1:0] STAT_BADREL   = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic [SLOT_W-1:0] release_slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted_slot;
		logic [1:0]        status;
	} rsp_t;

	// Write port of one of the two memories.
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic [SLOT_W-1:0] data;
	} fifo_wr_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic              data;
	} map_wr_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

@@ rtl/core/fflsp_fifo_mem.sv @@
module fflsp_fifo_mem (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [fflsp_pkg::SLOT_W-1:0] rd_addr,
	output logic [fflsp_pkg::SLOT_W-1:0] rd_data,
	input  fflsp_pkg::fifo_wr_t       wr
);
	import fflsp_pkg::*;

	logic [SLOT_W-1:0] mem [FIFO_DEPTH];
	logic [SLOT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/fflsp_map_mem.sv @@
module fflsp_map_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [fflsp_pkg::SLOT_W-1:0] rd_addr,
	output logic                      rd_data,
	input  fflsp_pkg::map_wr_t        wr
);
	import fflsp_pkg::*;

	logic mem [FIFO_DEPTH];
	logic [FIFO_DEPTH-1:0] vld_q;
	logic rd_mem_q;
	logic rd_vld_q;

	// Entries never written read as clear, which is the reset state of the bitmap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_mem_q <= mem[rd_addr];
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_mem_q & rd_vld_q;

endmodule

@@ rtl/core/fifo_free_list_slot_pool_top.sv @@
// Slot-handle pool with a FIFO free list. Each request transaction is an allocate, a
// try-allocate or a release, and each one produces exactly one response transaction.
// An allocate returns the oldest released handle, or, when none is queued, the next
// never-used slot from a fresh counter; once that counter reaches the pool capacity
// (POOL_SIZE, capped at 256 because handles are eight bits) it reports none available.
// A try-allocate uses only released handles. A release of an allocated handle clears
// its bit in the allocation bitmap and queues it; any other release reports an error.
// The free list and the bitmap live in two dual-port synchronous memories. The accept
// cycle of a request launches both memory reads, and the evaluate state that follows
// evaluates the request and writes both memories back. No new request is accepted until
// the last one has been evaluated, so the memory writes always land before the next read,
// and no forwarding is needed. A finished response waits in an output register, and a
// new request may be accepted meanwhile; it is held in its evaluate cycle until the
// output register is free. No clearing pass is needed after reset.
module fifo_free_list_slot_pool_top #(
	parameter int unsigned POOL_SIZE = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  fflsp_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output fflsp_pkg::rsp_t rsp
);
	import fflsp_pkg::*;

	localparam int unsigned CAP_INT = (POOL_SIZE < FIFO_DEPTH) ? POOL_SIZE : FIFO_DEPTH;
	localparam logic [COUNT_W-1:0] CAP = CAP_INT[COUNT_W-1:0];
	localparam logic [COUNT_W-1:0] DEPTH_C = FIFO_DEPTH[COUNT_W-1:0];

	state_t state_q, state_d;

	req_t               req_s1;
	logic [SLOT_W-1:0]  head_q, tail_q;
	logic [COUNT_W-1:0] count_q, fresh_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               accept;
	logic               fire;
	logic [SLOT_W-1:0]  fifo_rd_data;
	logic               map_rd_data;
	fifo_wr_t           fifo_wr;
	map_wr_t            map_wr;
	rsp_t               rsp_d;
	logic               pop, push, fresh_take;

	fflsp_fifo_mem u_fifo_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (head_q),
		.rd_data (fifo_rd_data),
		.wr      (fifo_wr)
	);

	fflsp_map_mem u_map_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (req.release_slot),
		.rd_data (map_rd_data),
		.wr      (map_wr)
	);

	// Control: one request at a time, evaluated in ST_EXEC after its reads.
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		fire      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// The response register must be empty or emptying.
				if (!(rsp_valid_q && rsp_stall)) begin
					fire    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = req_valid && !req_stall;

	// Evaluate the request against the memory read data.
	always_comb begin
		rsp_d      = '{granted_slot: '0, status: STAT_NONE};
		pop        = 1'b0;
		push       = 1'b0;
		fresh_take = 1'b0;
		fifo_wr    = '{en: 1'b0, addr: tail_q, data: req_s1.release_slot};
		map_wr     = '{en: 1'b0, addr: req_s1.release_slot, data: 1'b0};
		case (req_s1.action)
			ACT_ALLOC, ACT_TRY_ALLOC: begin
				if (count_q != '0) begin
					pop         = 1'b1;
					rsp_d       = '{granted_slot: fifo_rd_data, status: STAT_GRANTED};
					map_wr.en   = fire;
					map_wr.addr = fifo_rd_data;
					map_wr.data = 1'b1;
				end else if (req_s1.action == ACT_ALLOC && fresh_q < CAP) begin
					fresh_take  = 1'b1;
					rsp_d       = '{granted_slot: fresh_q[SLOT_W-1:0], status: STAT_GRANTED};
					map_wr.en   = fire;
					map_wr.addr = fresh_q[SLOT_W-1:0];
					map_wr.data = 1'b1;
				end
			end
			ACT_RELEASE: begin
				if ({1'b0, req_s1.release_slot} < CAP && map_rd_data && count_q < DEPTH_C) begin
					push       = 1'b1;
					rsp_d      = '{granted_slot: '0, status: STAT_RELEASED};
					map_wr.en  = fire;
					fifo_wr.en = fire;
				end else begin
					rsp_d = '{granted_slot: '0, status: STAT_BADREL};
				end
			end
			default: begin
				rsp_d = '{granted_slot: '0, status: STAT_NONE};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			fresh_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				if (pop) begin
					head_q  <= head_q + 1'b1;
					count_q <= count_q - 1'b1;
				end
				if (push) begin
					tail_q  <= tail_q + 1'b1;
					count_q <= count_q + 1'b1;
				end
				if (fresh_take) begin
					fresh_q <= fresh_q + 1'b1;
				end
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP)
		else $error("free list holds more handles than the pool capacity");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= CAP)
		else $error("fresh counter ran past the pool capacity");

	a_count_vs_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fresh_q)
		else $error("more handles queued than were ever handed out");

	a_fire_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (state_q == ST_IDLE && rsp_valid_q))
		else $error("evaluated request did not load the response register");

	a_zero_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != STAT_GRANTED) |-> (rsp_q.granted_slot == '0))
		else $error("nonzero handle on a response that grants nothing");
`endif

endmodule

@@ tb/fifo_free_list_slot_pool_top_test.sv @@
`timescale 1ns / 100ps

// Checks the slot pool by predicting every response transaction from the accepted request
// transactions. A short directed run hits the corner cases. Random traffic in four phases
// of varied idling drains the fresh counter and cycles handles through the free list.
module fifo_free_list_slot_pool_top_test;
	import fflsp_pkg::*;

	localparam int unsigned POOL_SIZE       = 256;
	localparam int unsigned SLOT_CAP        = (POOL_SIZE < FIFO_DEPTH) ? POOL_SIZE : FIFO_DEPTH;
	// The action code that the block does not define; it must be answered as none available.
	localparam logic [1:0]  ACT_UNUSED      = 2'd3;
	localparam int unsigned ITEMS_PER_PHASE = 488;
	localparam int unsigned BLOCK_LEN       = 100;
	localparam int unsigned ALLOC_BLOCKS    = 5;
	localparam int unsigned SETTLE_CYCLES   = 8;
	// The block holds at most two transactions at once, so a short ring of predictions is
	// plenty.
	localparam int unsigned EXPECT_DEPTH    = 16;
	// About 2000 requests plus gaps and stalls fit well within this limit, which leaves a
	// wide margin.
	localparam int unsigned CYCLE_LIMIT     = 200000;

	typedef enum int {
		MIX_ALLOC,
		MIX_BALANCED,
		MIX_RELEASE
	} mix_t;

	// Shadow copy of the pool. It predicts one response per accepted request and holds the
	// predictions in order until the block delivers them.
	class slot_pool_scoreboard;
		logic [SLOT_W-1:0]  free_list [FIFO_DEPTH];
		logic [SLOT_W-1:0]  head;
		logic [SLOT_W-1:0]  tail;
		logic [COUNT_W-1:0] free_count;
		logic [COUNT_W-1:0] fresh_count;
		logic [COUNT_W-1:0] cap;
		bit                 in_use [FIFO_DEPTH];
		rsp_t               expected [EXPECT_DEPTH];
		int unsigned        exp_head;
		int unsigned        exp_tail;
		int unsigned        exp_count;
		int unsigned        errors;
		int unsigned        checked;
		int unsigned        grants;
		int unsigned        releases;
		int unsigned        refusals;
		int unsigned        exhausted;
		int unsigned        bad_releases;

		function new(logic [COUNT_W-1:0] capacity);
			cap          = capacity;
			head         = '0;
			tail         = '0;
			free_count   = '0;
			fresh_count  = '0;
			exp_head     = 0;
			exp_tail     = 0;
			exp_count    = 0;
			errors       = 0;
			checked      = 0;
			grants       = 0;
			releases     = 0;
			refusals     = 0;
			exhausted    = 0;
			bad_releases = 0;
			foreach (in_use[i]) in_use[i] = 1'b0;
			foreach (free_list[i]) free_list[i] = '0;
		endfunction

		function int unsigned pending();
			return exp_count;
		endfunction

		function void note_request(req_t r);
			rsp_t res;
			res.granted_slot = '0;
			res.status       = STAT_NONE;
			case (r.action)
			ACT_ALLOC, ACT_TRY_ALLOC: begin
				if (free_count != '0) begin
					res.granted_slot = free_list[head];
					res.status       = STAT_GRANTED;
					head             = head + 8'd1;
					free_count       = free_count - 9'd1;
					in_use[res.granted_slot] = 1'b1;
				end else if (r.action == ACT_ALLOC && fresh_count < cap) begin
					res.granted_slot = fresh_count[SLOT_W-1:0];
					res.status       = STAT_GRANTED;
					fresh_count      = fresh_count + 9'd1;
					in_use[res.granted_slot] = 1'b1;
				end else if (r.action == ACT_ALLOC) begin
					exhausted++;
				end
			end
			ACT_RELEASE: begin
				if ({1'b0, r.release_slot} < cap && in_use[r.release_slot] &&
						free_count < COUNT_W'(FIFO_DEPTH)) begin
					in_use[r.release_slot] = 1'b0;
					free_list[tail]        = r.release_slot;
					tail                   = tail + 8'd1;
					free_count             = free_count + 9'd1;
					res.status             = STAT_RELEASED;
				end else begin
					res.status = STAT_BADREL;
				end
			end
			default: begin
			end
			endcase
			case (res.status)
			STAT_GRANTED:  grants++;
			STAT_RELEASED: releases++;
			STAT_NONE:     refusals++;
			default:       bad_releases++;
			endcase
			if (exp_count == EXPECT_DEPTH) begin
				$error("more than %0d responses outstanding", EXPECT_DEPTH);
				errors++;
			end else begin
				expected[exp_tail] = res;
				exp_tail           = (exp_tail + 1) % EXPECT_DEPTH;
				exp_count++;
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (exp_count == 0) begin
				$error("unexpected response: granted_slot %0d, status %0d",
					got.granted_slot, got.status);
				errors++;
				return;
			end
			want     = expected[exp_head];
			exp_head = (exp_head + 1) % EXPECT_DEPTH;
			exp_count--;
			checked++;
			if (got.granted_slot !== want.granted_slot) begin
				$error("granted_slot: expected %0d, actual %0d", want.granted_slot,
					got.granted_slot);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
		endfunction

		// Finds some handle that is currently out, starting the search at a random place.
		function bit pick_held(output logic [SLOT_W-1:0] slot);
			int unsigned start;
			start = $urandom_range(0, FIFO_DEPTH - 1);
			for (int unsigned k = 0; k < FIFO_DEPTH; k++) begin
				if (in_use[(start + k) % FIFO_DEPTH]) begin
					slot = SLOT_W'((start + k) % FIFO_DEPTH);
					return 1'b1;
				end
			end
			slot = '0;
			return 1'b0;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cycles         = 0;

	slot_pool_scoreboard sb = new(COUNT_W'(SLOT_CAP));

	fifo_free_list_slot_pool_top #(
		.POOL_SIZE(POOL_SIZE)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// Watchdog. A hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The receiver stalls at random, with the rate set by the current phase. The stall
	// changes only at the falling edge, so the block sees a stable value at the rising edge.
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Every response transaction accepted at a rising edge is checked against the oldest
	// prediction. Values read here are the ones from before the edge.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_response(rsp);
		end
	end

	function automatic req_t make_req(logic [1:0] action, logic [SLOT_W-1:0] slot);
		req_t r;
		r.action       = action;
		r.release_slot = slot;
		return r;
	endfunction

	// Sends one request transaction. The sender may idle first, with the rate of the current
	// phase; while idle the payload carries junk. Once valid is up it stays up with a fixed
	// payload until the block takes it, and the prediction is made at that very edge.
	task automatic send_request(input req_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			req_valid = 1'b0;
			req       = make_req(2'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 255)));
		end
		@(negedge clk);
		req_valid = 1'b1;
		req       = item;
		do @(posedge clk); while (req_stall);
		sb.note_request(item);
	endtask

	// Holds the sender off until every predicted response has come back, then lets the
	// block settle.
	task automatic wait_drained();
		@(negedge clk);
		req_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random traffic. Most releases name a handle that is really out, so that the free list
	// fills and drains. The noise share uses every action code, the unused one too, with any
	// handle, which mostly gives double releases and releases of handles never handed out.
	function automatic req_t pick_request(mix_t mix);
		req_t              r;
		int unsigned       roll;
		int unsigned       w_alloc;
		int unsigned       w_try;
		int unsigned       w_rel;
		logic [SLOT_W-1:0] slot;
		r = make_req(ACT_ALLOC, SLOT_W'($urandom_range(0, 255)));
		case (mix)
		MIX_ALLOC: begin
			w_alloc = 70;
			w_try   = 5;
			w_rel   = 15;
		end
		MIX_BALANCED: begin
			w_alloc = 35;
			w_try   = 15;
			w_rel   = 40;
		end
		default: begin
			w_alloc = 15;
			w_try   = 20;
			w_rel   = 55;
		end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < w_alloc) begin
			r.action = ACT_ALLOC;
		end else if (roll < w_alloc + w_try) begin
			r.action = ACT_TRY_ALLOC;
		end else if (roll < w_alloc + w_try + w_rel) begin
			r.action = ACT_RELEASE;
			if (sb.pick_held(slot)) begin
				r.release_slot = slot;
			end
		end else begin
			r.action = 2'($urandom_range(0, 3));
		end
		return r;
	endfunction

	initial begin
		mix_t        mix;
		int unsigned block_count;
		mix         = MIX_ALLOC;
		block_count = 0;
		req_valid   = 1'b0;
		req         = '0;
		arst_n      = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. A try-allocate on an empty pool is refused, fresh slots come out in
		// order and the release handle is ignored on allocates. The unused action code leaves
		// an allocated handle alone. A double release and a release of a handle never handed
		// out are both errors, and released handles come back oldest first.
		send_request(make_req(ACT_TRY_ALLOC, 8'd0));
		send_request(make_req(ACT_ALLOC, 8'd0));
		send_request(make_req(ACT_RELEASE, 8'd255));
		send_request(make_req(ACT_ALLOC, 8'd255));
		send_request(make_req(ACT_ALLOC, 8'd0));
		send_request(make_req(ACT_UNUSED, 8'd0));
		send_request(make_req(ACT_RELEASE, 8'd1));
		send_request(make_req(ACT_RELEASE, 8'd1));
		send_request(make_req(ACT_RELEASE, 8'd0));
		send_request(make_req(ACT_TRY_ALLOC, 8'd255));
		send_request(make_req(ACT_ALLOC, 8'd0));
		send_request(make_req(ACT_TRY_ALLOC, 8'd0));
		send_request(make_req(ACT_ALLOC, 8'd170));
		send_request(make_req(ACT_RELEASE, 8'd2));
		send_request(make_req(ACT_RELEASE, 8'd3));
		send_request(make_req(ACT_RELEASE, 8'd0));
		send_request(make_req(ACT_UNUSED, 8'd255));
		send_request(make_req(ACT_ALLOC, 8'd85));
		send_request(make_req(ACT_TRY_ALLOC, 8'd0));
		send_request(make_req(ACT_TRY_ALLOC, 8'd0));
		send_request(make_req(ACT_RELEASE, 8'd4));
		send_request(make_req(ACT_TRY_ALLOC, 8'd0));

		// The sender holds off here until the block has answered everything.
		wait_drained();

		// Phase 0 has no idling, phase 1 an idle sender, phase 2 a stalling receiver and
		// phase 3 both. The first blocks are allocate heavy so that the fresh counter runs
		// out early. After that the mix changes at random, so that the free list fills up,
		// empties, and allocates are refused on an exhausted pool.
		for (int unsigned phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 62;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 62;
			end
			default: begin
				send_idle_pct  = 29;
				recv_stall_pct = 29;
			end
			endcase
			for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i % BLOCK_LEN == 0) begin
					if (block_count < ALLOC_BLOCKS) begin
						mix = MIX_ALLOC;
					end else begin
						mix = mix_t'($urandom_range(0, 2));
					end
					block_count++;
				end
				send_request(pick_request(mix));
			end
			wait_drained();
		end

		$display("Checked %0d responses: %0d grants, %0d releases, %0d bad releases,",
			sb.checked, sb.grants, sb.releases, sb.bad_releases);
		$display("and %0d refusals, %0d of them allocates on an exhausted pool.",
			sb.refusals, sb.exhausted);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
